FILE: hdl/bba_pkg.sv
// Package for the buddy block allocator: constants, state and status codes.
// No dependencies.
package bba_pkg;

    localparam int NUM_TOP_BLOCKS_DEF  = 16;
    localparam int NUM_CLASSES_DEF     = 13;
    localparam int MIN_BLOCK_BYTES_DEF = 512;
    localparam int ADDR_W  = 48;
    localparam int BYTES_W = 23;
    localparam int WORD_W  = 64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FIND_RD,
        S_FIND_CHK,
        S_SPLIT,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_ANC_RD,
        S_ANC_CHK,
        S_MRG_RD,
        S_MRG_CHK,
        S_SET_RD,
        S_SET_WR,
        S_DONE
    } state_t;

endpackage

FILE: hdl/bba_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hdl/buddy_block_allocator_core.sv
// Top level of the buddy block allocator: sequencer plus free-bitmap memory.
// Depends on bba_pkg and bba_ram.
//
// channel | signals                                     | handshake
// request | start, req_type, block_bytes, block_address | start & !busy
// result  | done, result_address, status                | done, one cycle, no stall
// config  | cfg_valid, cfg_ready, cfg_data              | cfg_valid & cfg_ready
//
// Every bitmap access goes through the single RAM port: issue read, then check
// and write back the same word. A bad size or bad offset goes from decode
// straight to the result strobe. Allocate checks each bit of a class in turn,
// moves up past an exhausted class without a read, and marks the upper half
// free at each split level. Free checks each ancestor level, probes the buddy
// at each merge level, then sets the bit. A clearing pass after reset sets the
// top-class bits; busy high, cfg_ready low meanwhile. Results cannot be stalled.
module buddy_block_allocator_core #(
    parameter int NUM_TOP_BLOCKS  = bba_pkg::NUM_TOP_BLOCKS_DEF,
    parameter int NUM_CLASSES     = bba_pkg::NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [bba_pkg::BYTES_W-1:0] block_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]  block_address,
    output logic                        done,
    output logic [bba_pkg::ADDR_W-1:0]  result_address,
    output logic [1:0]                  status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bba_pkg::ADDR_W-1:0]  cfg_data
);
    import bba_pkg::*;

    localparam int  TOTAL_BITS = NUM_TOP_BLOCKS * ((1 << NUM_CLASSES) - 1);
    localparam int  WORDS      = (TOTAL_BITS + WORD_W - 1) / WORD_W;
    localparam int  WA_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int  WB_W       = $clog2(WORD_W);
    localparam int  BIT_W      = $clog2(TOTAL_BITS + 1) + 1;
    localparam int  CLS_W      = $clog2(NUM_CLASSES + 1);
    localparam int  MINL       = $clog2(MIN_BLOCK_BYTES);
    localparam int  POOL_L     = MINL + NUM_CLASSES - 1;
    localparam int  TOP_FIRST  = TOTAL_BITS - NUM_TOP_BLOCKS;
    localparam logic [ADDR_W:0] POOL_BYTES =
        (ADDR_W+1)'(NUM_TOP_BLOCKS) << POOL_L;
    localparam logic [CLS_W-1:0] TOP_C = CLS_W'(NUM_CLASSES - 1);

    state_t state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg;
    logic [WA_W-1:0]     clr_reg, clr_next;
    logic                op_reg, op_next;
    logic [CLS_W-1:0]    c_reg, c_next;    // requested class
    logic [CLS_W-1:0]    d_reg, d_next;    // current class
    logic [BIT_W-1:0]    k_reg, k_next;    // block index in class d
    logic [BIT_W-1:0]    kb_reg, kb_next;  // block index of request at class c
    logic [BYTES_W-1:0]  bytes_reg;
    logic [ADDR_W-1:0]   addr_reg;
    status_t             st_reg, st_next;
    logic [ADDR_W-1:0]   res_reg, res_next;
    logic [BIT_W-1:0]    tb_reg, tb_next;  // global bit under test

    // memory port
    logic              we;
    logic [WA_W-1:0]   ram_addr;
    logic [WORD_W-1:0] wdata, rdata;

    bba_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
    );

    // first bit of class d: N*(2^C - 2^(C-d))
    function automatic logic [BIT_W-1:0] first_bit(input logic [CLS_W-1:0] d);
        logic [BIT_W-1:0] a;
        a = (BIT_W'(1) << NUM_CLASSES) - (BIT_W'(1) << (CLS_W'(NUM_CLASSES) - d));
        return BIT_W'(a * NUM_TOP_BLOCKS);
    endfunction

    function automatic logic [BIT_W-1:0] class_cnt(input logic [CLS_W-1:0] d);
        return BIT_W'(BIT_W'(NUM_TOP_BLOCKS) << (TOP_C - d));
    endfunction

    logic [BIT_W-1:0]  probe_k;
    logic [BIT_W-1:0]  gbit;
    logic              bit_in_range;
    logic              cur_bit;
    logic [ADDR_W-1:0] off;
    logic              off_bad;
    logic [BIT_W-1:0]  kidx;
    logic              cls_ok;
    logic [CLS_W-1:0]  cls_found;

    // merge probes look at the buddy, everything else at the block itself
    assign probe_k      = (state_reg == S_MRG_RD) ? (k_reg ^ BIT_W'(1)) : k_reg;
    assign gbit         = first_bit(d_reg) + probe_k;
    assign bit_in_range = (k_reg < class_cnt(d_reg));
    assign cur_bit      = rdata[tb_reg[WB_W-1:0]];
    assign off          = addr_reg - base_reg;
    assign off_bad      = ({1'b0, off} >= POOL_BYTES) ||
                          ((off & ((ADDR_W'(1) << (MINL + cls_found)) - ADDR_W'(1))) != '0);
    assign kidx         = BIT_W'(off >> (MINL + cls_found));

    always_comb
    begin
        cls_ok    = 1'b0;
        cls_found = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (64'(bytes_reg) == (64'(MIN_BLOCK_BYTES) << i))
            begin
                cls_ok    = 1'b1;
                cls_found = CLS_W'(i);
            end
        end
    end

    // next state / datapath
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        k_next     = k_reg;
        kb_next    = kb_reg;
        st_next    = st_reg;
        res_next   = res_reg;
        tb_next    = tb_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + WA_W'(1);
                if (clr_reg == WA_W'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = req_type;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_next = '0;
                c_next   = cls_found;
                d_next   = cls_found;
                kb_next  = kidx;
                if (!cls_ok)
                begin
                    st_next    = ST_BAD_SIZE;
                    state_next = S_DONE;
                end
                else if (!op_reg)
                begin
                    k_next     = '0;
                    state_next = S_FIND_RD;
                end
                else if (off_bad)
                begin
                    st_next    = ST_BAD_ADDR;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = kidx;
                    state_next = S_ANC_RD;
                end
            end
            S_FIND_RD:
            begin
                // past the end of a class: move up one class without a read
                if (bit_in_range)
                begin
                    tb_next    = gbit;
                    state_next = S_FIND_CHK;
                end
                else if (d_reg == TOP_C)
                begin
                    st_next    = ST_EXHAUSTED;
                    state_next = S_DONE;
                end
                else
                begin
                    d_next = d_reg + CLS_W'(1);
                    k_next = '0;
                end
            end
            S_FIND_CHK:
            begin
                // a free bit is cleared in this cycle by the memory control
                if (cur_bit)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    k_next     = k_reg + BIT_W'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_SPLIT:
            begin
                if (d_reg == c_reg)
                begin
                    res_next   = base_reg + (ADDR_W'(k_reg) << (MINL + c_reg));
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    // upper half one level down becomes free
                    d_next     = d_reg - CLS_W'(1);
                    k_next     = (k_reg << 1) | BIT_W'(1);
                    state_next = S_SPLIT_RD;
                end
            end
            S_SPLIT_RD:
            begin
                tb_next    = gbit;
                state_next = S_SPLIT_WR;
            end
            S_SPLIT_WR:
            begin
                k_next     = k_reg & ~BIT_W'(1);
                state_next = S_SPLIT;
            end
            S_ANC_RD:
            begin
                tb_next    = gbit;
                state_next = S_ANC_CHK;
            end
            S_ANC_CHK:
            begin
                // block already free or inside a free larger block
                if (cur_bit)
                begin
                    st_next    = ST_BAD_ADDR;
                    state_next = S_DONE;
                end
                else if (d_reg == TOP_C)
                begin
                    d_next     = c_reg;
                    k_next     = kb_reg;
                    state_next = (c_reg == TOP_C) ? S_SET_RD : S_MRG_RD;
                end
                else
                begin
                    d_next     = d_reg + CLS_W'(1);
                    k_next     = k_reg >> 1;
                    state_next = S_ANC_RD;
                end
            end
            S_MRG_RD:
            begin
                tb_next    = gbit;
                state_next = S_MRG_CHK;
            end
            S_MRG_CHK:
            begin
                // free buddy is cleared in this cycle; merged block moves up
                if (cur_bit)
                begin
                    d_next     = d_reg + CLS_W'(1);
                    k_next     = k_reg >> 1;
                    state_next = ((d_reg + CLS_W'(1)) == TOP_C) ? S_SET_RD : S_MRG_RD;
                end
                else
                begin
                    state_next = S_SET_RD;
                end
            end
            S_SET_RD:
            begin
                tb_next    = gbit;
                state_next = S_SET_WR;
            end
            S_SET_WR:
            begin
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory address / write control
    always_comb
    begin
        we       = 1'b0;
        ram_addr = tb_reg[WA_W+WB_W-1:WB_W];
        wdata    = rdata;
        case (state_reg)
            S_CLEAR:
            begin
                ram_addr = clr_reg;
                we       = 1'b1;
                for (int b = 0; b < WORD_W; b++)
                begin
                    wdata[b] = (BIT_W'({clr_reg, WB_W'(b)}) >= BIT_W'(TOP_FIRST)) &&
                               (BIT_W'({clr_reg, WB_W'(b)}) < BIT_W'(TOTAL_BITS));
                end
            end
            S_FIND_RD, S_SPLIT_RD, S_ANC_RD, S_MRG_RD, S_SET_RD:
            begin
                ram_addr = gbit[WA_W+WB_W-1:WB_W];
            end
            S_FIND_CHK, S_MRG_CHK:
            begin
                we                      = cur_bit;
                wdata[tb_reg[WB_W-1:0]] = 1'b0;
            end
            S_SPLIT_WR, S_SET_WR:
            begin
                we                      = 1'b1;
                wdata[tb_reg[WB_W-1:0]] = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            base_reg  <= '0;
            op_reg    <= 1'b0;
            c_reg     <= '0;
            d_reg     <= '0;
            k_reg     <= '0;
            kb_reg    <= '0;
            st_reg    <= ST_OK;
            res_reg   <= '0;
            tb_reg    <= '0;
            bytes_reg <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            op_reg    <= op_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            k_reg     <= k_next;
            kb_reg    <= kb_next;
            st_reg    <= st_next;
            res_reg   <= res_next;
            tb_reg    <= tb_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
            if (start && !busy)
            begin
                bytes_reg <= block_bytes;
                addr_reg  <= block_address;
            end
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = (state_reg == S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign result_address = (st_reg == ST_OK) ? res_reg : '0;
    assign status         = st_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("done not followed by idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted request not busy");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> result_address == '0)
        else $error("error result carries address");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("config accepted while busy");
endmodule
